// ===== hw/rtl/salc_pkg.sv =====
// Shared constants and types of the set-associative LRU tag store.
package salc_pkg;

    // Configuration port.
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_W-1:0]     t_cfg_val;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_OFFSET_BITS = 2'd0;
    localparam t_cfg_idx CFG_INDEX_BITS  = 2'd1;
    localparam t_cfg_idx CFG_WAYS_IN_USE = 2'd2;

    localparam t_cfg_val RST_OFFSET_BITS = 4'd6;
    localparam t_cfg_val RST_INDEX_BITS  = 4'd6;
    localparam t_cfg_val RST_WAYS_IN_USE = 4'd1;

    // Width of the reported set number.
    localparam int OUT_SET_W = 9;

    typedef logic [OUT_SET_W-1:0] t_set_num;

endpackage

// ===== hw/rtl/salc_in_if.sv =====
// Address channel into the tag store.
interface salc_in_if #(
    parameter int ADDR_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

// ===== hw/rtl/salc_out_if.sv =====
// Hit/miss result channel out of the tag store.
interface salc_out_if;
    import salc_pkg::*;

    logic     valid;
    logic     ready;
    logic     hit;
    t_set_num set_number;

    modport source (output valid, output hit, output set_number, input ready);
    modport sink   (input valid, input hit, input set_number, output ready);
endinterface

// ===== hw/rtl/set_assoc_lru_cache_tags_top.sv =====
// Top level of the set-associative tag store with true LRU replacement.
//
// Usage: each word on the i_in channel is one byte address. The block splits
// it into block offset, set index and tag using the offset_bits and
// index_bits registers, searches the first ways_in_use ways of that set, and
// returns one word on o_out: the hit flag and the set number the address
// mapped to. A hit makes the matching way most recent; a miss overwrites the
// least recent way in use with the new tag and makes it most recent.
// Each set is one row of a single RAM: all tags, valid bits and ranks.
// Flow: the row read is registered with the address into stage 1, where the
// compare and the row write-back are done as the result register is loaded.
// Throughput: one address per cycle while o_out.ready is high. The row read
// is issued as the address is taken, the update is written back as the word
// leaves stage 1, and a following access to the same set takes the updated
// row from a forwarding register. Reset: after i_rst_n the block sweeps the
// row RAM once, one set per cycle, marking every way invalid and restoring
// the ranks; i_in.ready stays low during the sweep. Configuration writes are
// taken at any time and must only be issued while no word is in flight.
// Stall: when o_out.ready is low the result register holds its word, and
// one more address is taken only if stage 1 is empty before i_in.ready drops.
module set_assoc_lru_cache_tags_top #(
    parameter int MAX_SETS   = 512,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    salc_in_if.sink             i_in,
    salc_out_if.source          o_out,
    input  logic                i_cfg_we,
    input  salc_pkg::t_cfg_idx  i_cfg_idx,
    input  salc_pkg::t_cfg_val  i_cfg_wdata
);
    import salc_pkg::*;

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int KMAX    = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W  = WAY_W;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int SHAMT_W = CFG_W + 1;
    localparam int TAGS_W  = MAX_WAYS * ADDR_WIDTH;
    localparam int RANKS_W = MAX_WAYS * RANK_W;
    localparam int ROW_W   = TAGS_W + RANKS_W + MAX_WAYS;
    localparam int SEEN_N  = 2 ** RANK_W;

    // Configuration registers.
    t_cfg_val r_offset_bits;
    t_cfg_val r_index_bits;
    t_cfg_val r_ways_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= RST_OFFSET_BITS;
            r_index_bits  <= RST_INDEX_BITS;
            r_ways_in_use <= RST_WAYS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_wdata;
                CFG_INDEX_BITS:  r_index_bits  <= i_cfg_wdata;
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective index width and associativity after clamping.
    t_cfg_val          ib_eff;
    logic [WCNT_W-1:0] nways;

    always_comb begin
        if (int'(r_index_bits) > KMAX) begin
            ib_eff = CFG_W'(KMAX);
        end else begin
            ib_eff = r_index_bits;
        end
        if (r_ways_in_use == '0) begin
            nways = WCNT_W'(1);
        end else if (int'(r_ways_in_use) > MAX_WAYS) begin
            nways = WCNT_W'(MAX_WAYS);
        end else begin
            nways = WCNT_W'(r_ways_in_use);
        end
    end

    // Control registers.
    logic                  r_clr_busy;
    logic [SET_W-1:0]      r_clr_idx;
    logic                  r_s1_valid;
    logic [ADDR_WIDTH-1:0] r_s1_addr;
    logic [SET_W-1:0]      r_s1_set;
    logic                  r_fwd_valid;
    logic [SET_W-1:0]      r_fwd_set;
    logic [ROW_W-1:0]      r_fwd_row;
    logic                  r_out_valid;
    logic                  r_out_hit;
    t_set_num              r_out_set;

    logic             in_fire;
    logic             s1_go;
    logic [SET_W-1:0] n_s1_set;
    logic [SET_W-1:0] set_mask;

    // Stage 1 completes when the result register is free or being emptied.
    assign s1_go    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_clr_busy && (!r_s1_valid || s1_go);
    assign in_fire  = i_in.valid && i_in.ready;

    assign set_mask = ~({SET_W{1'b1}} << ib_eff);
    assign n_s1_set = SET_W'(i_in.address >> r_offset_bits) & set_mask;

    // Row RAM: one row per set holding every way's tag, rank and valid bit.
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] clr_row;
    logic [ROW_W-1:0] n_row;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (n_s1_set),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = r_clr_busy || s1_go;
    assign ram_waddr = r_clr_busy ? r_clr_idx : r_s1_set;
    assign ram_wdata = r_clr_busy ? clr_row : n_row;

    always_comb begin
        clr_row = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            clr_row[TAGS_W + w*RANK_W +: RANK_W] = RANK_W'(w);
        end
    end

    // Stage 1: look up the set row and build its updated copy.
    logic [ROW_W-1:0]      cur_row;
    logic [ADDR_WIDTH-1:0] cur_tag   [MAX_WAYS];
    logic [RANK_W-1:0]     cur_rank  [MAX_WAYS];
    logic [MAX_WAYS-1:0]   cur_valid;
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   is_oldest;
    logic [ADDR_WIDTH-1:0] s1_tag;
    logic [SHAMT_W-1:0]    tag_shift;
    logic                  s1_hit;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      s1_victim;
    logic [WAY_W-1:0]      touched;
    logic [RANK_W-1:0]     touched_rank;
    logic [RANK_W-1:0]     new_rank  [MAX_WAYS];
    logic [SEEN_N-1:0]     rank_seen;

    assign cur_row   = (r_fwd_valid && r_fwd_set == r_s1_set) ? r_fwd_row : ram_rdata;
    assign tag_shift = SHAMT_W'(r_offset_bits) + SHAMT_W'(ib_eff);
    assign s1_tag    = r_s1_addr >> tag_shift;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            cur_tag[w]   = cur_row[w*ADDR_WIDTH +: ADDR_WIDTH];
            cur_rank[w]  = cur_row[TAGS_W + w*RANK_W +: RANK_W];
            cur_valid[w] = cur_row[TAGS_W + RANKS_W + w];
            in_use[w]    = WCNT_W'(w) < nways;
        end

        // Lowest matching way wins.
        s1_hit  = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (in_use[w] && cur_valid[w] && cur_tag[w] == s1_tag) begin
                s1_hit  = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        // The victim is the way in use whose rank is not below any other.
        for (int w = 0; w < MAX_WAYS; w++) begin
            is_oldest[w] = in_use[w];
            for (int v = 0; v < MAX_WAYS; v++) begin
                if (in_use[v] && cur_rank[v] > cur_rank[w]) begin
                    is_oldest[w] = 1'b0;
                end
            end
        end
        s1_victim = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (is_oldest[w]) begin
                s1_victim = WAY_W'(w);
            end
        end

        touched      = s1_hit ? hit_way : s1_victim;
        touched_rank = cur_rank[touched];

        n_row     = cur_row;
        rank_seen = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == touched) begin
                new_rank[w] = '0;
            end else if (cur_rank[w] < touched_rank) begin
                new_rank[w] = cur_rank[w] + RANK_W'(1);
            end else begin
                new_rank[w] = cur_rank[w];
            end
            n_row[TAGS_W + w*RANK_W +: RANK_W] = new_rank[w];
            rank_seen[new_rank[w]] = 1'b1;
        end
        if (!s1_hit) begin
            n_row[s1_victim*ADDR_WIDTH +: ADDR_WIDTH] = s1_tag;
            n_row[TAGS_W + RANKS_W + s1_victim]       = 1'b1;
        end
    end

    // Clearing sweep, pipeline control and forwarding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
                if (r_clr_idx == SET_W'(MAX_SETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (r_clr_busy) begin
                r_fwd_valid <= 1'b0;
            end else if (s1_go) begin
                r_fwd_valid <= 1'b1;
            end

            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_addr <= i_in.address;
            r_s1_set  <= n_s1_set;
        end
        if (s1_go) begin
            r_fwd_set <= r_s1_set;
            r_fwd_row <= n_row;
            r_out_hit <= s1_hit;
            r_out_set <= OUT_SET_W'(r_s1_set);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hit        = r_out_hit;
    assign o_out.set_number = r_out_set;

    // No address may enter while the sweep is still rewriting rows.
    a_no_accept_in_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_fire)
        else $error("address taken during clearing sweep");

    // A taken address always occupies the lookup stage in the next cycle.
    a_accept_fills_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted address lost before lookup");

    // Written-back ranks stay a permutation of the ways.
    a_rank_perm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |-> ($countones(rank_seen) == MAX_WAYS))
        else $error("rank update broke the permutation");

    // A replaced way is always one of the ways in use.
    a_victim_in_use : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !s1_hit) |-> in_use[s1_victim])
        else $error("victim outside the ways in use");

endmodule

// ===== hw/rtl/salc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== dv/salc_checker.sv =====
// Checker that predicts and compares every hit/miss word of the LRU tag store.
module salc_checker #(
    parameter int MAX_SETS   = 512,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    salc_in_if                 in_ch,
    salc_out_if                out_ch,
    input  logic               i_cfg_we,
    input  salc_pkg::t_cfg_idx i_cfg_idx,
    input  salc_pkg::t_cfg_val i_cfg_wdata,
    output int                 o_outstanding,
    output int                 o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import salc_pkg::*;

    localparam int KMAX   = $clog2(MAX_SETS + 1) - 1;
    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef struct packed {
        logic     hit;
        t_set_num set_number;
    } t_lookup;

    logic [ADDR_WIDTH-1:0] tag_mem  [MAX_SETS][MAX_WAYS];
    bit                    way_live [MAX_SETS][MAX_WAYS];
    logic [RANK_W-1:0]     age_rank [MAX_SETS][MAX_WAYS];

    t_cfg_val offset_bits_q;
    t_cfg_val index_bits_q;
    t_cfg_val ways_q;

    t_lookup hitmiss_q[$];

    function automatic void clear_tag_model();
        for (int s = 0; s < MAX_SETS; s++) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                way_live[s][w] = 1'b0;
                age_rank[s][w] = RANK_W'(w);
            end
        end
        offset_bits_q = RST_OFFSET_BITS;
        index_bits_q  = RST_INDEX_BITS;
        ways_q        = RST_WAYS_IN_USE;
    endfunction

    // Make one way most recent; every way that was more recent ages by one.
    function automatic void promote_way(int set_i, int way_i);
        logic [RANK_W-1:0] r;
        r = age_rank[set_i][way_i];
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (age_rank[set_i][w] < r) begin
                age_rank[set_i][w] = age_rank[set_i][w] + 1'b1;
            end
        end
        age_rank[set_i][way_i] = '0;
    endfunction

    function automatic t_lookup lookup_lru(logic [ADDR_WIDTH-1:0] addr);
        t_lookup               res;
        int                    ib;
        int                    nways;
        int                    set_i;
        int                    victim;
        logic [ADDR_WIDTH-1:0] tag;
        logic [ADDR_WIDTH-1:0] set_mask;
        ib     = (int'(index_bits_q) > KMAX) ? KMAX : int'(index_bits_q);
        nways  = int'(ways_q);
        victim = 0;
        if (nways == 0) begin
            nways = 1;
        end
        if (nways > MAX_WAYS) begin
            nways = MAX_WAYS;
        end
        set_mask = (ADDR_WIDTH'(1) << ib) - 1'b1;
        set_i    = int'((addr >> offset_bits_q) & set_mask);
        tag      = addr >> (int'(offset_bits_q) + ib);
        res.hit        = 1'b0;
        res.set_number = t_set_num'(set_i);
        for (int w = 0; w < nways; w++) begin
            if (!res.hit && way_live[set_i][w] && tag_mem[set_i][w] == tag) begin
                res.hit = 1'b1;
                promote_way(set_i, w);
            end
        end
        if (!res.hit) begin
            for (int w = 1; w < nways; w++) begin
                if (age_rank[set_i][w] > age_rank[set_i][victim]) begin
                    victim = w;
                end
            end
            tag_mem[set_i][victim]  = tag;
            way_live[set_i][victim] = 1'b1;
            promote_way(set_i, victim);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup exp_word;
        if (!i_rst_n) begin
            clear_tag_model();
            hitmiss_q.delete();
            o_outstanding <= 0;
            o_fail_count  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFFSET_BITS: offset_bits_q = i_cfg_wdata;
                    CFG_INDEX_BITS:  index_bits_q  = i_cfg_wdata;
                    CFG_WAYS_IN_USE: ways_q        = i_cfg_wdata;
                    default: ;
                endcase
            end
            // Results are retired before new addresses are predicted, so a word
            // can never be matched against the address taken at the same edge.
            if (out_ch.valid && out_ch.ready) begin
                if (hitmiss_q.size() == 0) begin
                    $display("%0t: unexpected result word hit=%0b set=%0d",
                             $time, out_ch.hit, out_ch.set_number);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_word = hitmiss_q.pop_front();
                    if (out_ch.hit !== exp_word.hit ||
                        out_ch.set_number !== exp_word.set_number) begin
                        if (out_ch.hit !== exp_word.hit) begin
                            $display("%0t: hit expected %0b actual %0b",
                                     $time, exp_word.hit, out_ch.hit);
                        end
                        if (out_ch.set_number !== exp_word.set_number) begin
                            $display("%0t: set_number expected %0d actual %0d",
                                     $time, exp_word.set_number, out_ch.set_number);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                hitmiss_q.push_back(lookup_lru(in_ch.address));
            end
            o_outstanding <= hitmiss_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the testbench for the set-associative LRU tag store: stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import salc_pkg::*;

    localparam int MAX_SETS   = 512;
    localparam int MAX_WAYS   = 8;
    localparam int ADDR_WIDTH = 32;
    localparam int KMAX       = 9;
    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 175;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    t_cfg_idx cfg_idx;
    t_cfg_val cfg_wdata;
    int       outstanding;
    int       fail_count;

    // Words left in the current burst of the address sender.
    int       burst_left;

    salc_in_if #(.ADDR_WIDTH(ADDR_WIDTH)) in_ch ();
    salc_out_if                           out_ch ();

    set_assoc_lru_cache_tags_top #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    salc_checker #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_outstanding(outstanding),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop. The slowest correct run is well under a tenth of this: about
    // 1800 words, each facing at most a short sender gap and a receiver stall,
    // plus the reset sweep of the row RAM and the drains between phases.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result receiver. It alternates runs of ready with stalls of random
    // length, and now and then stays ready for a long stretch so that the
    // block also runs at full rate with nothing holding it back.
    initial begin
        int hi_len;
        int lo_len;
        forever begin
            hi_len = $urandom_range(1, 30);
            lo_len = $urandom_range(1, 10);
            if ($urandom_range(0, 7) == 0) begin
                hi_len = 200;
            end
            out_ch.ready <= 1'b1;
            repeat (hi_len) @(posedge clk);
            out_ch.ready <= 1'b0;
            repeat (lo_len) @(posedge clk);
        end
    end

    // Present one address and hold it until the block takes it. Between bursts
    // the sender goes quiet for a random number of cycles; a zero gap keeps
    // valid high so that valid never drops and rises in the same step.
    task automatic send_addr(input logic [ADDR_WIDTH-1:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid   <= 1'b1;
        in_ch.address <= addr;
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
    endtask

    // Stop sending and wait until every word in flight has come back. The
    // first edge lets the checker count a word taken at the last edge.
    task automatic drain_words();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One register write; the caller drops the write enable after the last one,
    // so back-to-back writes keep it high without a second assignment per edge.
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_val val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Registers only change while the block is idle; the store is not cleared,
    // so old entries are seen through the new address split.
    task automatic set_geometry(input t_cfg_val off, input t_cfg_val ib, input t_cfg_val ways);
        drain_words();
        write_reg(CFG_OFFSET_BITS, off);
        write_reg(CFG_INDEX_BITS, ib);
        write_reg(CFG_WAYS_IN_USE, ways);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [ADDR_WIDTH-1:0] pool [16];
        logic [ADDR_WIDTH-1:0] base;
        logic [ADDR_WIDTH-1:0] addr;
        logic [ADDR_WIDTH-1:0] off_mask;
        logic [ADDR_WIDTH-1:0] set_mask;
        t_cfg_val              off;
        t_cfg_val              ib;
        t_cfg_val              ways;
        int                    ib_eff;
        int                    pool_n;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_OFFSET_BITS;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.address <= '0;
        burst_left    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. First the reset geometry: one way, 64-byte blocks,
        // 64 sets. Both address extremes, hits inside the same block, and a
        // conflict in set zero that evicts the only way.
        send_addr(32'h0000_0000);
        send_addr(32'hFFFF_FFFF);
        send_addr(32'h0000_003F);
        send_addr(32'hFFFF_FFC0);
        send_addr(32'h0000_1000);
        send_addr(32'h0000_0000);

        // One set of eight ways with the whole address as the tag: nine
        // distinct tags push out the least recent one.
        set_geometry(4'd0, 4'd0, 4'd8);
        for (int i = 1; i <= 9; i++) begin
            send_addr(ADDR_WIDTH'(i));
        end
        send_addr(32'h0000_0001);
        send_addr(32'h0000_0009);

        // Two ways hold neighbouring tags; a wider offset then shifts the new tag so
        // that neither stored tag matches, and the lookup misses.
        set_geometry(4'd0, 4'd0, 4'd2);
        send_addr(32'h0000_0010);
        send_addr(32'h0000_0011);
        set_geometry(4'd4, 4'd0, 4'd2);
        send_addr(32'h0000_0010);

        // Out-of-range settings: zero ways acts as one, too many index bits
        // are clamped, and too many ways acts as all of them.
        set_geometry(4'd15, 4'd15, 4'd0);
        send_addr(32'hFFFF_FFFF);
        send_addr(32'h7FFF_FFFF);
        set_geometry(4'd12, 4'd9, 4'd15);
        send_addr(32'hFFFF_F000);
        send_addr(32'h0000_0FFF);

        // Random part. Each phase picks a geometry (the extremes first) and a
        // small pool of addresses, some forced into one set, so that hits,
        // LRU evictions and thrashing all happen; a quarter of the words are
        // fully random addresses.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin off = 4'd0;  ib = 4'd0;  ways = 4'd1;  end
                1: begin off = 4'd12; ib = 4'd9;  ways = 4'd8;  end
                2: begin off = 4'd0;  ib = 4'd9;  ways = 4'd8;  end
                3: begin off = 4'd12; ib = 4'd0;  ways = 4'd1;  end
                default: begin
                    off  = ($urandom_range(0, 5) == 0) ? t_cfg_val'($urandom_range(0, 15))
                                                       : t_cfg_val'($urandom_range(0, 12));
                    ib   = ($urandom_range(0, 5) == 0) ? t_cfg_val'($urandom_range(0, 15))
                                                       : t_cfg_val'($urandom_range(0, 9));
                    ways = ($urandom_range(0, 5) == 0) ? t_cfg_val'($urandom_range(0, 15))
                                                       : t_cfg_val'($urandom_range(1, 8));
                end
            endcase
            set_geometry(off, ib, ways);

            ib_eff   = (int'(ib) > KMAX) ? KMAX : int'(ib);
            off_mask = (ADDR_WIDTH'(1) << off) - 1'b1;
            set_mask = ((ADDR_WIDTH'(1) << ib_eff) - 1'b1) << off;
            base     = $urandom;
            pool_n   = $urandom_range(1, 12);
            for (int i = 0; i < pool_n; i++) begin
                pool[i] = $urandom;
                if ($urandom_range(0, 1) == 1) begin
                    pool[i] = (pool[i] & ~set_mask) | (base & set_mask);
                end
            end

            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    addr = $urandom;
                end else begin
                    addr = pool[$urandom_range(0, pool_n - 1)];
                    addr = (addr & ~off_mask) | ($urandom & off_mask);
                end
                send_addr(addr);
            end
        end

        // Wind down: every address has been taken; wait for the last words.
        drain_words();
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/salc_pkg.sv
hw/rtl/salc_in_if.sv
hw/rtl/salc_out_if.sv
hw/rtl/salc_ram.sv
hw/rtl/set_assoc_lru_cache_tags_top.sv
dv/salc_checker.sv
dv/tb_top.sv
